// File: rtl/core/gram_pkg.sv
`timescale 1ns / 1ps
// Package for the graph reachability marking block: field widths, reset
// values, operation codes and the merge-stage result struct.
// No dependencies.
package gram_pkg;

   // Fixed field widths
   localparam int MASK_W    = 16;
   localparam int ROW_IDX_W = 4;
   localparam int COUNT_W   = 5;

   // Reset value of the vertex count register
   localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd16;

   // Default size of the adjacency store
   localparam int MAX_VERTICES_DEFAULT = 16;

   // Request operation codes
   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_RUN  = 1'b1
   } op_type;

   // Outcome of one marking pass
   typedef struct packed {
      logic [MASK_W-1:0] next_marks;
      logic              grew;
   } merge_type;

endpackage

// File: rtl/core/gram_lane.sv
`timescale 1ns / 1ps
// One marking lane: passes the successors of its vertex when that vertex
// is marked, restricted to the vertices in use.
// Depends on gram_pkg.
module gram_lane (
   input  logic                         mark_bit,
   input  logic [gram_pkg::MASK_W-1:0]  row_edges,
   input  logic [gram_pkg::MASK_W-1:0]  use_mask,
   output logic [gram_pkg::MASK_W-1:0]  lane_word
);

   // Successors of a marked vertex, unused vertices dropped
   assign lane_word = mark_bit ? (row_edges & use_mask) : '0;

endmodule

// File: rtl/core/gram_merge.sv
`timescale 1ns / 1ps
// Merge stage: ORs the lane words into the current marks and flags
// whether the pass added any vertex.
// Depends on gram_pkg.
module gram_merge #(
   parameter int NumLanes = 16
) (
   input  logic [gram_pkg::MASK_W-1:0] lane_words [NumLanes],
   input  logic [gram_pkg::MASK_W-1:0] marks,
   output gram_pkg::merge_type         merge_out
);

   logic [gram_pkg::MASK_W-1:0] union_word;

   // OR reduction across lanes
   always_comb begin
      union_word = marks;
      for (int i = 0; i < NumLanes; i++) begin
         union_word = union_word | lane_words[i];
      end
   end

   assign merge_out.next_marks = union_word;
   assign merge_out.grew       = (union_word != marks);

endmodule

// File: rtl/core/graph_reachability_marking.sv
`timescale 1ns / 1ps
// Graph reachability marking over an adjacency matrix loaded row by row.
// A row load is taken while idle and busy stays low. A run takes P marking
// passes, one per cycle, with P between 1 and the in-use vertex count (never
// below 1; a pass that adds nothing ends it); busy is high while the passes
// run and the result strobes in the cycle after the last pass. The lane
// array and merge stage set the one-pass-per-cycle loop.
// Synchronous active-high reset clears control state and sets vertex_count
// to 16; adjacency rows are undefined until loaded. The receiver cannot stall.
// Depends on gram_pkg, gram_lane and gram_merge.
module graph_reachability_marking #(
   parameter int MAX_VERTICES = gram_pkg::MAX_VERTICES_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            start,
   output logic                            busy,
   input  logic                            req_operation,
   input  logic [gram_pkg::ROW_IDX_W-1:0]  req_row_index,
   input  logic [gram_pkg::MASK_W-1:0]     req_row_edges,
   input  logic [gram_pkg::ROW_IDX_W-1:0]  req_source_vertex,
   // result channel
   output logic                            rsp_valid,
   output logic [gram_pkg::MASK_W-1:0]     rsp_reached_mask,
   // configuration channel
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [gram_pkg::COUNT_W-1:0]    csr_vertex_count
);

   // Only rows that a 4-bit index can reach, and no more than the store holds
   localparam int NumLanes = (MAX_VERTICES < gram_pkg::MASK_W) ? MAX_VERTICES
                                                                : gram_pkg::MASK_W;
   localparam int RowW     = $clog2(NumLanes);

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   state_type                        state_ff, state_in;
   logic [gram_pkg::MASK_W-1:0]      marks_ff, marks_in;
   logic [gram_pkg::MASK_W-1:0]      use_ff, use_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [gram_pkg::MASK_W-1:0]      rsp_mask_ff, rsp_mask_in;
   logic [gram_pkg::COUNT_W-1:0]     count_ff, count_in;

   logic [gram_pkg::MASK_W-1:0]      rows_ff [NumLanes];
   logic [gram_pkg::MASK_W-1:0]      lane_words [NumLanes];
   logic [gram_pkg::MASK_W-1:0]      use_mask;
   gram_pkg::merge_type              merge_out;
   logic                             req_xfer;
   logic                             load_xfer;
   logic                             run_xfer;

   assign busy      = (state_ff == ST_RUN);
   assign csr_ready = 1'b1;
   assign req_xfer  = start && !busy;
   assign load_xfer = req_xfer && (req_operation == gram_pkg::OP_LOAD);
   assign run_xfer  = req_xfer && (req_operation == gram_pkg::OP_RUN);

   // In-use vertices: below both the count register and the store depth
   always_comb begin
      for (int v = 0; v < gram_pkg::MASK_W; v++) begin
         use_mask[v] = (v < NumLanes) && (int'(count_ff) > v);
      end
   end

   // Adjacency store, one row per lane
   always_ff @(posedge clock) begin
      if (load_xfer && (int'(req_row_index) < NumLanes)) begin
         rows_ff[req_row_index[RowW-1:0]] <= req_row_edges;
      end
   end

   // Lane array
   for (genvar x = 0; x < NumLanes; x++) begin : g_lane
      gram_lane u_lane (
         .mark_bit  (marks_ff[x]),
         .row_edges (rows_ff[x]),
         .use_mask  (use_ff),
         .lane_word (lane_words[x])
      );
   end

   gram_merge #(
      .NumLanes (NumLanes)
   ) u_merge (
      .lane_words (lane_words),
      .marks      (marks_ff),
      .merge_out  (merge_out)
   );

   // Next-state logic
   always_comb begin
      state_in     = state_ff;
      marks_in     = marks_ff;
      use_in       = use_ff;
      rsp_valid_in = 1'b0;
      rsp_mask_in  = rsp_mask_ff;
      count_in     = count_ff;
      if (csr_valid && csr_ready) begin
         count_in = csr_vertex_count;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (run_xfer) begin
               state_in = ST_RUN;
               use_in   = use_mask;
               // source outside the in-use range marks nothing
               marks_in = use_mask[req_source_vertex] ?
                          (gram_pkg::MASK_W'(1) << req_source_vertex) : '0;
            end
         end
         ST_RUN: begin
            marks_in = merge_out.next_marks;
            if (!merge_out.grew) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_mask_in  = marks_ff;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= gram_pkg::COUNT_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
      marks_ff    <= marks_in;
      use_ff      <= use_in;
      rsp_mask_ff <= rsp_mask_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_reached_mask = rsp_mask_ff;

   // A result only follows a marking pass
   a_rsp_after_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result strobe without a preceding run pass");

   // Result never names a vertex outside the in-use range of its run
   a_rsp_in_use: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_reached_mask & ~use_ff) == '0))
      else $error("result marks a vertex that is not in use");

   // Marks only grow while a run is in progress
   a_marks_grow: assert property (@(posedge clock) disable iff (reset)
      (busy && $past(busy)) |-> ((marks_ff & $past(marks_ff)) == $past(marks_ff)))
      else $error("marking pass dropped a marked vertex");

endmodule

// File: sim/tb_graph_reachability_marking.sv
`timescale 1ns / 1ps
// Self-checking testbench for graph_reachability_marking: row loads and marking
// runs with random gaps, checked against a fixed-point reachability predictor.
// Depends on gram_pkg and the graph_reachability_marking RTL.
module tb_graph_reachability_marking;

   localparam int HALF_PERIOD  = 6;
   localparam int RESET_CYCLES = 12;
   localparam int SETTLE       = 20;    // covers the longest run plus the strobe
   localparam int QUIET_LIMIT  = 2000;
   localparam int PHASE_ITEMS  = 118;

   // Package values used throughout
   localparam int MASK_W               = gram_pkg::MASK_W;
   localparam int ROW_IDX_W            = gram_pkg::ROW_IDX_W;
   localparam int COUNT_W              = gram_pkg::COUNT_W;
   localparam int MAX_VERTICES_DEFAULT = gram_pkg::MAX_VERTICES_DEFAULT;

   // One pending command for the request channel
   typedef struct {
      gram_pkg::op_type     op;
      logic [ROW_IDX_W-1:0] row;
      logic [MASK_W-1:0]    edges;
      logic [ROW_IDX_W-1:0] src;
      int unsigned          idle;   // cycles with start low before this command
      bit                   hold;   // wait for every open run to return first
   } graph_cmd_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic                 req_operation = 1'b0;
   logic [ROW_IDX_W-1:0] req_row_index = '0;
   logic [MASK_W-1:0]    req_row_edges = '0;
   logic [ROW_IDX_W-1:0] req_source_vertex = '0;
   logic                 rsp_valid;
   logic [MASK_W-1:0]    rsp_reached_mask;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [COUNT_W-1:0]   csr_vertex_count = '0;

   // Predictor state
   logic [MASK_W-1:0]    adj_rows [MAX_VERTICES_DEFAULT];
   logic [COUNT_W-1:0]   count_model = gram_pkg::COUNT_RESET;

   graph_cmd_type        cmd_q [$];
   graph_cmd_type        cur;
   logic [MASK_W-1:0]    mask_q [$];
   int unsigned          idle_cnt = 0;
   int unsigned          runs_sent = 0;
   int unsigned          results_seen = 0;
   int unsigned          load_total = 0;
   int unsigned          run_total = 0;
   int unsigned          setting_total = 1;
   int unsigned          quiet = 0;
   int unsigned          errors = 0;

   graph_reachability_marking u_top (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_operation     (req_operation),
      .req_row_index     (req_row_index),
      .req_row_edges     (req_row_edges),
      .req_source_vertex (req_source_vertex),
      .rsp_valid         (rsp_valid),
      .rsp_reached_mask  (rsp_reached_mask),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_vertex_count  (csr_vertex_count)
   );

   always #HALF_PERIOD clock = ~clock;

   // Vertices reachable from src, iterated until a pass adds nothing
   function automatic logic [MASK_W-1:0] reach_set(input logic [ROW_IDX_W-1:0] src);
      int unsigned       n;
      logic [MASK_W-1:0] use_mask;
      logic [MASK_W-1:0] marks;
      logic [MASK_W-1:0] grown;
      bit                grew;
      n = (count_model > MAX_VERTICES_DEFAULT) ? MAX_VERTICES_DEFAULT : count_model;
      use_mask = (n >= MASK_W) ? '1 : MASK_W'((17'd1 << n) - 17'd1);
      if (src >= n) return '0;
      marks = MASK_W'(1) << src;
      grew = 1'b1;
      while (grew) begin
         grown = marks;
         for (int x = 0; x < n; x++)
            if (marks[x]) grown |= adj_rows[x] & use_mask;
         grew = (grown != marks);
         marks = grown;
      end
      return marks;
   endfunction

   // Mostly sparse rows so that reachability stays interesting
   function automatic logic [MASK_W-1:0] draw_edges();
      logic [MASK_W-1:0] e;
      case ($urandom_range(0, 5))
         0: e = '0;
         1: e = '1;
         2: e = MASK_W'($urandom);
         default: begin
            e = MASK_W'(1) << $urandom_range(0, MASK_W - 1);
            if ($urandom_range(0, 1)) e |= MASK_W'(1) << $urandom_range(0, MASK_W - 1);
         end
      endcase
      return e;
   endfunction

   task automatic push_cmd(input gram_pkg::op_type op, input logic [ROW_IDX_W-1:0] row,
                           input logic [MASK_W-1:0] edges,
                           input logic [ROW_IDX_W-1:0] src, input bit no_idle,
                           input bit hold);
      graph_cmd_type c;
      c.op    = op;
      c.row   = row;
      c.edges = edges;
      c.src   = src;
      c.idle  = no_idle ? 0 : $urandom_range(0, 19);
      c.hold  = hold;
      cmd_q.push_back(c);
   endtask

   // Full matrix load with a descending chain, then runs across it
   task automatic queue_directed();
      logic [MASK_W-1:0] e;
      for (int x = 0; x < MAX_VERTICES_DEFAULT; x++) begin
         if (x == 0) e = '0;
         else if (x == MAX_VERTICES_DEFAULT - 1) e = '1;
         else e = MASK_W'(1) << (x - 1);
         push_cmd(gram_pkg::OP_LOAD, ROW_IDX_W'(x), e, ROW_IDX_W'($urandom), 1'b0, 1'b0);
      end
      push_cmd(gram_pkg::OP_RUN, ROW_IDX_W'($urandom), MASK_W'($urandom), 4'd0, 1'b0, 1'b0);
      push_cmd(gram_pkg::OP_RUN, ROW_IDX_W'($urandom), MASK_W'($urandom), 4'd14, 1'b0, 1'b0);
      push_cmd(gram_pkg::OP_RUN, ROW_IDX_W'($urandom), MASK_W'($urandom), 4'd15, 1'b0, 1'b0);
      // close a loop from a low vertex back to the top one
      push_cmd(gram_pkg::OP_LOAD, 4'd2, 16'h8000, ROW_IDX_W'($urandom), 1'b0, 1'b1);
      push_cmd(gram_pkg::OP_RUN, ROW_IDX_W'($urandom), MASK_W'($urandom), 4'd5, 1'b0, 1'b0);
      push_cmd(gram_pkg::OP_RUN, ROW_IDX_W'($urandom), MASK_W'($urandom), 4'd1, 1'b0, 1'b0);
   endtask

   // Random mix of single loads, runs and path-shaped load sequences
   task automatic queue_random(input int count, input bit no_idle);
      int          added;
      int          pick;
      int          len;
      int          j;
      int          tmp;
      int          perm [MAX_VERTICES_DEFAULT];
      int unsigned n;
      logic [ROW_IDX_W-1:0] src;
      added = 0;
      n = (count_model > MAX_VERTICES_DEFAULT) ? MAX_VERTICES_DEFAULT : count_model;
      while (added < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 10) begin
            // path through a shuffled vertex order, then run from its head
            for (int i = 0; i < MAX_VERTICES_DEFAULT; i++) perm[i] = i;
            for (int i = MAX_VERTICES_DEFAULT - 1; i > 0; i--) begin
               j = $urandom_range(0, i);
               tmp = perm[i];
               perm[i] = perm[j];
               perm[j] = tmp;
            end
            len = $urandom_range(2, MAX_VERTICES_DEFAULT);
            for (int i = 0; i < len - 1; i++)
               push_cmd(gram_pkg::OP_LOAD, ROW_IDX_W'(perm[i]), MASK_W'(1) << perm[i + 1],
                        ROW_IDX_W'($urandom), no_idle, 1'b0);
            push_cmd(gram_pkg::OP_RUN, ROW_IDX_W'($urandom), MASK_W'($urandom),
                     ROW_IDX_W'(perm[0]), no_idle, 1'b0);
            added += len;
         end else if (pick < 45) begin
            push_cmd(gram_pkg::OP_LOAD, ROW_IDX_W'($urandom), draw_edges(),
                     ROW_IDX_W'($urandom), no_idle, $urandom_range(0, 39) == 0);
            added++;
         end else begin
            if (n > 0 && $urandom_range(0, 99) < 85) src = ROW_IDX_W'($urandom_range(0, n - 1));
            else src = ROW_IDX_W'($urandom);
            push_cmd(gram_pkg::OP_RUN, ROW_IDX_W'($urandom), MASK_W'($urandom), src, no_idle,
                     $urandom_range(0, 39) == 0);
            added++;
         end
      end
   endtask

   // Block is idle once every command went out and every run came back
   task automatic wait_idle();
      while (cmd_q.size() != 0 || start || runs_sent != results_seen) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_count(input logic [COUNT_W-1:0] value);
      csr_valid        <= 1'b1;
      csr_vertex_count <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid   <= 1'b0;
      count_model = value;
      setting_total++;
   endtask

   // Request driver: predicts each transfer, then presents the next command
   always @(posedge clock) begin
      bit          took_run;
      int unsigned gap;
      int unsigned open_runs;
      if (reset) begin
         start    <= 1'b0;
         idle_cnt <= 0;
      end else begin
         took_run = 1'b0;
         if (start && !busy) begin
            if (cur.op == gram_pkg::OP_LOAD) begin
               adj_rows[cur.row] = cur.edges;
               load_total++;
            end else begin
               mask_q.push_back(reach_set(cur.src));
               took_run = 1'b1;
               run_total++;
            end
         end
         open_runs = runs_sent + int'(took_run) - results_seen - int'(rsp_valid);
         if (took_run) runs_sent <= runs_sent + 1;
         gap = (start && !busy) ? 0 : idle_cnt;
         if (start && busy) begin
            // hold the command until it is taken
         end else if (cmd_q.size() != 0 && gap >= cmd_q[0].idle &&
                      (!cmd_q[0].hold || open_runs == 0)) begin
            cur = cmd_q.pop_front();
            start             <= 1'b1;
            req_operation     <= cur.op;
            req_row_index     <= cur.row;
            req_row_edges     <= cur.edges;
            req_source_vertex <= cur.src;
            idle_cnt          <= 0;
         end else begin
            start    <= 1'b0;
            idle_cnt <= gap + 1;
         end
      end
   end

   // Result monitor: every strobe must match the oldest predicted mask
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         results_seen <= results_seen + 1;
         if (mask_q.size() == 0) begin
            $error("unexpected result: reached_mask actual %h", rsp_reached_mask);
            errors++;
         end else if (rsp_reached_mask !== mask_q[0]) begin
            $error("reached_mask mismatch: expected %h, actual %h", mask_q[0],
                   rsp_reached_mask);
            errors++;
            void'(mask_q.pop_front());
         end else begin
            void'(mask_q.pop_front());
         end
      end
   end

   // Watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
         $display("tb_graph_reachability_marking: errors");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   // Phase sequencer: directed part at the reset count, then one phase per setting
   initial begin
      logic [COUNT_W-1:0] settings [10];
      settings = '{5'd1, 5'd0, 5'd31, 5'd16, 5'd17, 5'd2, 5'd7, 5'd12, 5'd15, 5'd9};
      settings[8] = COUNT_W'($urandom);
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      queue_directed();
      wait_idle();
      for (int p = 0; p < 10; p++) begin
         write_count(settings[p]);
         queue_random(PHASE_ITEMS, p == 3);
         wait_idle();
      end
      if (mask_q.size() != 0) begin
         $error("%0d predicted reached_mask values never returned", mask_q.size());
         errors++;
      end
      $display("covered %0d row loads and %0d marking runs over %0d vertex counts,",
               load_total, run_total, setting_total);
      $display("including zero, saturated and out-of-range sources");
      if (errors == 0) begin
         $display("tb_graph_reachability_marking: clean");
      end else begin
         $display("tb_graph_reachability_marking: errors");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/core/gram_pkg.sv
rtl/core/gram_lane.sv
rtl/core/gram_merge.sv
rtl/core/graph_reachability_marking.sv
sim/tb_graph_reachability_marking.sv
